// ===== rtl/timestamped_history_interpolator_defines.svh =====
// ---------------------------------------------------------------------------
// Timestamped history interpolator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TIMESTAMPED_HISTORY_INTERPOLATOR_DEFINES_SVH
`define TIMESTAMPED_HISTORY_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication.
`define THI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define THI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/thi_pkg.sv =====
// ---------------------------------------------------------------------------
// Timestamped history interpolator package
// Types, constants and codes shared by the interpolator modules.
// ---------------------------------------------------------------------------
`default_nettype none

package thi_pkg;

  localparam int HIST_DEPTH = 16;
  localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  localparam int FRAC_BITS  = 16;
  localparam int FRAC_W     = FRAC_BITS + 3;
  localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(4 << FRAC_BITS);
  localparam int QUOT_W     = FRAC_BITS + 2;
  localparam int DCNT_W     = $clog2(QUOT_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECORD_ENABLE = 2'd0,
    CFG_MIN_SAMPLE_GAP = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    ACT_STORE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    OWN_NONE   = 2'd0,
    OWN_ASLEEP = 2'd1,
    OWN_AWAKE  = 2'd2
  } owner_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ST_CHK,
    S_Q_RD,
    S_Q_CHK,
    S_EVAL,
    S_DIV,
    S_MUL,
    S_ACC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } sample_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    sample_t          data;
  } wr_req_t;

endpackage

`default_nettype wire

// ===== rtl/thi_if.sv =====
// ---------------------------------------------------------------------------
// Timestamped history interpolator channels
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface thi_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [1:0]  owner_state;
  logic [31:0] now_time;
  logic [31:0] lagged_time;
  logic signed [31:0] cur_x;
  logic signed [31:0] cur_y;
  logic signed [31:0] cur_z;

  modport source (output valid, action, owner_state, now_time, lagged_time,
                  cur_x, cur_y, cur_z, input ready);
  modport sink (input valid, action, owner_state, now_time, lagged_time,
                cur_x, cur_y, cur_z, output ready);
endinterface

interface thi_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic        compensated;
  logic        recorded;

  modport source (output valid, out_x, out_y, out_z, compensated, recorded,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, compensated, recorded,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/timestamped_history_interpolator.sv =====
// ---------------------------------------------------------------------------
// Timestamped history interpolator
// Records timestamped positions in a ring memory and answers lagged-position
// queries by walking back through the ring and interpolating.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake     Contents
//  in_ch     sink       valid/ready   action, owner, times, current position
//  out_ch    source     valid/ready   position, compensated, recorded
//  cfg_*     write      cfg_we        record_enable, min_sample_gap
//
//  A store transaction passes through a check state to the output state. A
//  query with no awake owner goes straight to the output state; otherwise the
//  walk reads the newest slot and then each older slot (one memory read each),
//  at most 16 slots; if a sample is found, the serial divider (skipped when
//  the fraction clamps) and the three multiplies follow. Reset is synchronous
//  and needs no clearing pass. One transaction is in work at a time; a
//  finished result waits in the output register while the next input is taken.
// ---------------------------------------------------------------------------
`default_nettype none

`include "timestamped_history_interpolator_defines.svh"

module timestamped_history_interpolator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  thi_in_if.sink                               in_ch,
  thi_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [thi_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [thi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam logic [thi_pkg::IDX_W-1:0] LAST_IDX = thi_pkg::IDX_W'(thi_pkg::HIST_DEPTH - 1);

  thi_pkg::state_t state_r, state_nxt;

  logic        rec_en_r;
  logic [15:0] min_gap_r;

  logic [thi_pkg::IDX_W-1:0] newest_r;
  logic [thi_pkg::IDX_W-1:0] idx_r;
  logic [thi_pkg::IDX_W-1:0] cnt_r;
  logic [thi_pkg::IDX_W-1:0] raddr;
  logic [thi_pkg::IDX_W-1:0] next_slot;
  logic [thi_pkg::IDX_W-1:0] prev_slot;

  logic [1:0]  own_r;
  logic [31:0] now_r;
  logic [31:0] lag_r;
  logic signed [31:0] cx_r, cy_r, cz_r;

  logic        found_r;
  thi_pkg::sample_t ch_r;
  thi_pkg::sample_t rdata;
  thi_pkg::wr_req_t wr;

  logic [thi_pkg::FRAC_W-1:0] frac_r;
  logic [1:0]  ax_r;
  logic signed [52:0] prod_r;
  logic signed [31:0] res_x_r, res_y_r, res_z_r;
  logic        res_comp_r, res_rec_r;

  logic        out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic        out_comp_r, out_rec_r;

  logic        in_hs;
  logic        store_ok;
  logic        walk_stop;
  logic [31:0] base;
  logic [31:0] num;
  logic        clamp;
  logic        div_start;
  logic        div_done;
  logic [thi_pkg::QUOT_W-1:0] quot;
  logic        out_load;

  logic signed [31:0] ax_cur;
  logic signed [31:0] ax_hist;
  logic signed [32:0] ax_diff;
  logic signed [36:0] ax_step;
  logic signed [37:0] ax_sum;
  logic signed [31:0] ax_sat;

  assign in_ch.ready = (state_r == thi_pkg::S_IDLE);
  assign in_hs       = in_ch.valid && in_ch.ready;

  assign next_slot = (newest_r == LAST_IDX) ? '0 : newest_r + 1'b1;
  assign prev_slot = (idx_r == '0) ? LAST_IDX : idx_r - 1'b1;

  assign store_ok = (own_r == thi_pkg::OWN_AWAKE) && rec_en_r && (now_r >= rdata.t) &&
                    ((now_r - rdata.t) >= {16'd0, min_gap_r});

  assign walk_stop = (rdata.t == '0) || (rdata.t <= lag_r) || (cnt_r == LAST_IDX);

  assign base  = now_r - ch_r.t;
  assign num   = now_r - lag_r;
  assign clamp = {2'b00, num} >= {base, 2'b00};

  assign out_load = (state_r == thi_pkg::S_OUT) && (!out_valid_r || out_ch.ready);

  thi_hist_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  thi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .base  (base),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      thi_pkg::S_IDLE: begin
        if (in_hs) begin
          if (in_ch.action == thi_pkg::ACT_STORE) begin
            state_nxt = thi_pkg::S_ST_CHK;
          end else if (in_ch.owner_state == thi_pkg::OWN_AWAKE) begin
            state_nxt = thi_pkg::S_Q_CHK;
          end else begin
            state_nxt = thi_pkg::S_OUT;
          end
        end
      end
      thi_pkg::S_ST_CHK: state_nxt = thi_pkg::S_OUT;
      thi_pkg::S_Q_RD:   state_nxt = thi_pkg::S_Q_CHK;
      thi_pkg::S_Q_CHK:  state_nxt = walk_stop ? thi_pkg::S_EVAL : thi_pkg::S_Q_RD;
      thi_pkg::S_EVAL: begin
        if (!found_r || (now_r <= ch_r.t)) begin
          state_nxt = thi_pkg::S_OUT;
        end else if ((lag_r >= now_r) || clamp) begin
          state_nxt = thi_pkg::S_MUL;
        end else begin
          state_nxt = thi_pkg::S_DIV;
        end
      end
      thi_pkg::S_DIV:    state_nxt = div_done ? thi_pkg::S_MUL : thi_pkg::S_DIV;
      thi_pkg::S_MUL:    state_nxt = thi_pkg::S_ACC;
      thi_pkg::S_ACC:    state_nxt = (ax_r == 2'd2) ? thi_pkg::S_OUT : thi_pkg::S_MUL;
      thi_pkg::S_OUT:    state_nxt = out_load ? thi_pkg::S_IDLE : thi_pkg::S_OUT;
      default:           state_nxt = thi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    raddr     = idx_r;
    div_start = 1'b0;
    wr.we     = 1'b0;
    wr.addr   = next_slot;
    wr.data   = '{t: now_r, x: cx_r, y: cy_r, z: cz_r};
    unique case (state_r)
      thi_pkg::S_IDLE:   raddr = newest_r;
      thi_pkg::S_ST_CHK: wr.we = store_ok;
      thi_pkg::S_EVAL: begin
        div_start = found_r && (now_r > ch_r.t) && (lag_r < now_r) && !clamp;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (ax_r)
      2'd0:    begin ax_cur = cx_r; ax_hist = ch_r.x; end
      2'd1:    begin ax_cur = cy_r; ax_hist = ch_r.y; end
      default: begin ax_cur = cz_r; ax_hist = ch_r.z; end
    endcase
    ax_diff = 33'(ax_hist) - 33'(ax_cur);
    ax_step = prod_r[52:16];
    ax_sum  = 38'(ax_cur) + 38'(ax_step);
    if (ax_sum > 38'sd2147483647) begin
      ax_sat = 32'sh7FFFFFFF;
    end else if (ax_sum < -38'sd2147483648) begin
      ax_sat = 32'sh80000000;
    end else begin
      ax_sat = ax_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_hs) begin
      own_r <= in_ch.owner_state;
      now_r <= in_ch.now_time;
      lag_r <= in_ch.lagged_time;
      cx_r  <= in_ch.cur_x;
      cy_r  <= in_ch.cur_y;
      cz_r  <= in_ch.cur_z;
      if (in_ch.action == thi_pkg::ACT_STORE || in_ch.owner_state == thi_pkg::OWN_NONE) begin
        res_x_r <= '0;
        res_y_r <= '0;
        res_z_r <= '0;
      end else begin
        res_x_r <= in_ch.cur_x;
        res_y_r <= in_ch.cur_y;
        res_z_r <= in_ch.cur_z;
      end
      res_comp_r <= 1'b0;
      res_rec_r  <= 1'b0;
    end
    if (state_r == thi_pkg::S_ST_CHK) begin
      res_rec_r <= store_ok;
    end
    if (state_r == thi_pkg::S_Q_CHK && rdata.t != '0) begin
      ch_r <= rdata;
    end
    if (state_r == thi_pkg::S_EVAL) begin
      frac_r <= (lag_r >= now_r) ? '0 : thi_pkg::FRAC_MAX;
      ax_r   <= 2'd0;
    end
    if (state_r == thi_pkg::S_DIV && div_done) begin
      frac_r <= thi_pkg::FRAC_W'(quot);
    end
    if (state_r == thi_pkg::S_MUL) begin
      prod_r <= ax_diff * $signed({1'b0, frac_r});
    end
    if (state_r == thi_pkg::S_ACC) begin
      case (ax_r)
        2'd0:    res_x_r <= ax_sat;
        2'd1:    res_y_r <= ax_sat;
        default: res_z_r <= ax_sat;
      endcase
      ax_r       <= ax_r + 1'b1;
      res_comp_r <= 1'b1;
    end
    if (out_load) begin
      out_x_r    <= res_x_r;
      out_y_r    <= res_y_r;
      out_z_r    <= res_z_r;
      out_comp_r <= res_comp_r;
      out_rec_r  <= res_rec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= thi_pkg::S_IDLE;
      rec_en_r    <= 1'b1;
      min_gap_r   <= 16'd64;
      newest_r    <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          thi_pkg::CFG_RECORD_ENABLE:  rec_en_r  <= cfg_wdata[0];
          thi_pkg::CFG_MIN_SAMPLE_GAP: min_gap_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (wr.we) begin
        newest_r <= next_slot;
      end
      if (in_hs) begin
        idx_r   <= newest_r;
        cnt_r   <= '0;
        found_r <= 1'b0;
      end
      if (state_r == thi_pkg::S_Q_CHK) begin
        if (rdata.t != '0) begin
          found_r <= 1'b1;
        end
        if (!walk_stop) begin
          idx_r <= prev_slot;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_x       = out_x_r;
  assign out_ch.out_y       = out_y_r;
  assign out_ch.out_z       = out_z_r;
  assign out_ch.compensated = out_comp_r;
  assign out_ch.recorded    = out_rec_r;

  `THI_ASSERT_NXT(a_newest_follows_write, wr.we, newest_r == $past(wr.addr), "newest slot lost a write")
  `THI_ASSERT_IMP(a_frac_in_range, state_r == thi_pkg::S_MUL, frac_r <= thi_pkg::FRAC_MAX, "fraction above clamp")
  `THI_ASSERT_IMP(a_div_done_in_div, div_done, state_r == thi_pkg::S_DIV, "divider finished outside its wait state")
  `THI_ASSERT_IMP(a_result_kind, out_valid_r, !(out_comp_r && out_rec_r), "result both compensated and recorded")

endmodule

`default_nettype wire

// ===== rtl/thi_hist_mem.sv =====
// ---------------------------------------------------------------------------
// Sample history memory
// One write port and one registered read port; unwritten entries read as zero.
// ---------------------------------------------------------------------------
`default_nettype none

module thi_hist_mem (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire thi_pkg::wr_req_t        wr,
  input  wire logic [thi_pkg::IDX_W-1:0] raddr,
  output thi_pkg::sample_t             rdata
);

  thi_pkg::sample_t mem [thi_pkg::HIST_DEPTH];
  logic [thi_pkg::HIST_DEPTH-1:0] valid_r;
  thi_pkg::sample_t rd_r;
  logic rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.we) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[raddr];
    end
  end

  assign rdata = rd_valid_r ? rd_r : '0;

endmodule

`default_nettype wire

// ===== rtl/thi_div.sv =====
// ---------------------------------------------------------------------------
// Fraction divider
// Restoring division, one quotient bit per cycle, of num * 2^16 by base.
// The caller guarantees num < 4 * base, so the quotient fits in 18 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module thi_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] base,
  output logic             done,
  output logic [thi_pkg::QUOT_W-1:0] quot
);

  logic                         busy_r;
  logic                         done_r;
  logic [thi_pkg::DCNT_W-1:0]   cnt_r;
  logic [31:0]                  rem_r;
  logic [31:0]                  base_r;
  logic [thi_pkg::QUOT_W-1:0]   sh_r;
  logic [thi_pkg::QUOT_W-1:0]   q_r;
  logic [32:0]                  rem_sh;
  logic                         ge;
  logic [32:0]                  diff;

  assign rem_sh = {rem_r, sh_r[thi_pkg::QUOT_W-1]};
  assign ge     = rem_sh >= {1'b0, base_r};
  assign diff   = rem_sh - {1'b0, base_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {2'b00, num[31:2]};
      sh_r   <= {num[1:0], {thi_pkg::FRAC_BITS{1'b0}}};
      base_r <= base;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : rem_sh[31:0];
      sh_r  <= {sh_r[thi_pkg::QUOT_W-2:0], 1'b0};
      q_r   <= {q_r[thi_pkg::QUOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == thi_pkg::DCNT_W'(thi_pkg::QUOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire
